// ===== design/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, constants and calendar helper functions for the Gregorian
// date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

    localparam int ADD_WIDTH   = 16;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int OP_W        = 2;
    localparam int ACC_W       = ADD_WIDTH + 1;   // day plus added days
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 32;

    localparam logic [YEAR_W-1:0]  BASE_YEAR  = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] DEC_MONTH  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   LAST_DAY   = DAY_W'(31);

    // y / 100 for y below 2**14 as (y * 5243) >> 19
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_COMPARE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAP,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_LEAP,
        CMD_NEXT_MONTH,
        CMD_NEXT_YEAR,
        CMD_SATURATE,
        CMD_COMMIT
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fits;     // working day lies within working month
        logic            dec;      // working month is December
        logic            at_max;   // working year is the last one
    } status_t;

    function automatic logic leap_of(input logic [YEAR_W-1:0] y);
        logic [YEAR_W+13:0] prod;
        logic [YEAR_W-1:0]  q;
        logic [YEAR_W-1:0]  r;
        logic [YEAR_W+6:0]  q100;
        prod = (YEAR_W+14)'(y) * (YEAR_W+14)'(DIV100_MUL);
        q    = YEAR_W'(prod >> DIV100_SHIFT);
        q100 = ((YEAR_W+7)'(q) << 6) + ((YEAR_W+7)'(q) << 5) + ((YEAR_W+7)'(q) << 2);
        r    = y - YEAR_W'(q100);
        return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== design/gdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdc_ctrl
// Sequencer for the date counter: takes one word, walks the datapath through
// leap-year lookups and month steps, and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module gdc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  gdc_pkg::status_t status,
    output gdc_pkg::cmd_t    cmd
);

    gdc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    gdc_pkg::op_t    op;

    assign op       = gdc_pkg::op_t'(status.op);
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gdc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        cmd            = gdc_pkg::CMD_NONE;
        s_tready       = 1'b0;
        case (state_reg)
            gdc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd = gdc_pkg::CMD_CAPTURE;
                    // status.op is not yet captured: decide after the capture
                    state_next = gdc_pkg::ST_LEAP;
                end
            end
            gdc_pkg::ST_LEAP: begin
                if (op == gdc_pkg::OP_ADVANCE) begin
                    cmd        = gdc_pkg::CMD_LEAP;
                    state_next = gdc_pkg::ST_STEP;
                end else if (op == gdc_pkg::OP_LOAD) begin
                    cmd        = gdc_pkg::CMD_LEAP;
                    state_next = gdc_pkg::ST_FINISH;
                end else begin
                    state_next = gdc_pkg::ST_FINISH;
                end
            end
            gdc_pkg::ST_STEP: begin
                if (status.fits) begin
                    state_next = gdc_pkg::ST_FINISH;
                end else if (!status.dec) begin
                    cmd = gdc_pkg::CMD_NEXT_MONTH;
                end else if (status.at_max) begin
                    cmd        = gdc_pkg::CMD_SATURATE;
                    state_next = gdc_pkg::ST_FINISH;
                end else begin
                    // new year: refresh the leap flag before the next step
                    cmd        = gdc_pkg::CMD_NEXT_YEAR;
                    state_next = gdc_pkg::ST_LEAP;
                end
            end
            gdc_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd            = gdc_pkg::CMD_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = gdc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gdc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/gdc_dp.sv =====
// ----------------------------------------------------------------------------
// gdc_dp
// Datapath for the date counter: stored date, working copy for advances,
// leap-year unit, month-length table and the result register.
// ----------------------------------------------------------------------------
module gdc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gdc_pkg::OP_W-1:0]      s_op,
    input  logic [gdc_pkg::YEAR_W-1:0]    s_year,
    input  logic [gdc_pkg::MONTH_W-1:0]   s_month,
    input  logic [gdc_pkg::DAY_W-1:0]     s_day,
    input  logic [gdc_pkg::ADD_WIDTH-1:0] s_days,
    input  gdc_pkg::cmd_t                 cmd,
    output gdc_pkg::status_t              status,
    output logic [gdc_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [gdc_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [gdc_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [gdc_pkg::DAY_W-1:0]   day_reg, day_next;

    logic [gdc_pkg::OP_W-1:0]    op_reg;
    logic [gdc_pkg::YEAR_W-1:0]  gy_reg;
    logic [gdc_pkg::MONTH_W-1:0] gm_reg;
    logic [gdc_pkg::DAY_W-1:0]   gd_reg;

    logic [gdc_pkg::YEAR_W-1:0]  wy_reg;
    logic [gdc_pkg::MONTH_W-1:0] wm_reg;
    logic [gdc_pkg::ACC_W-1:0]   wd_reg;
    logic                        leap_reg;
    logic                        oor_reg;

    logic [gdc_pkg::YEAR_W-1:0]  out_year_reg;
    logic [gdc_pkg::MONTH_W-1:0] out_month_reg;
    logic [gdc_pkg::DAY_W-1:0]   out_day_reg;
    logic                        out_invalid_reg, out_invalid_next;
    logic                        out_earlier_reg, out_earlier_next;
    logic                        out_oor_reg, out_oor_next;

    logic [gdc_pkg::DAY_W-1:0]   work_len;
    logic [gdc_pkg::DAY_W-1:0]   given_len;
    logic [gdc_pkg::YEAR_W-1:0]  leap_year_sel;
    logic                        load_bad;

    assign work_len  = gdc_pkg::month_len(wm_reg, leap_reg);
    assign given_len = gdc_pkg::month_len(gm_reg, leap_reg);
    assign leap_year_sel = (op_reg == gdc_pkg::OP_LOAD) ? gy_reg : wy_reg;

    assign status.op     = op_reg;
    assign status.fits   = (wd_reg <= gdc_pkg::ACC_W'(work_len));
    assign status.dec    = (wm_reg == gdc_pkg::DEC_MONTH);
    assign status.at_max = (wy_reg >= gdc_pkg::MAX_YEAR);

    assign load_bad = (gy_reg > gdc_pkg::MAX_YEAR) || (given_len == '0) ||
                      (gd_reg == '0) || (gd_reg > given_len);

    // committed date and flags for the finished operation
    always_comb begin
        year_next        = year_reg;
        month_next       = month_reg;
        day_next         = day_reg;
        out_invalid_next = 1'b0;
        out_earlier_next = 1'b0;
        out_oor_next     = 1'b0;
        case (gdc_pkg::op_t'(op_reg))
            gdc_pkg::OP_LOAD: begin
                if (load_bad) begin
                    out_invalid_next = 1'b1;
                end else begin
                    year_next  = gy_reg;
                    month_next = gm_reg;
                    day_next   = gd_reg;
                end
            end
            gdc_pkg::OP_ADVANCE: begin
                year_next    = wy_reg;
                month_next   = wm_reg;
                day_next     = gdc_pkg::DAY_W'(wd_reg);
                out_oor_next = oor_reg;
            end
            gdc_pkg::OP_COMPARE: begin
                if (year_reg != gy_reg) begin
                    out_earlier_next = (year_reg < gy_reg);
                end else if (month_reg != gm_reg) begin
                    out_earlier_next = (month_reg < gm_reg);
                end else begin
                    out_earlier_next = (day_reg < gd_reg);
                end
            end
            default: begin
                out_earlier_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg  <= gdc_pkg::BASE_YEAR;
            month_reg <= gdc_pkg::MONTH_W'(1);
            day_reg   <= gdc_pkg::DAY_W'(1);
        end else if (cmd == gdc_pkg::CMD_COMMIT) begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            gdc_pkg::CMD_CAPTURE: begin
                op_reg  <= s_op;
                gy_reg  <= s_year;
                gm_reg  <= s_month;
                gd_reg  <= s_day;
                wy_reg  <= year_reg;
                wm_reg  <= month_reg;
                wd_reg  <= gdc_pkg::ACC_W'(day_reg) + gdc_pkg::ACC_W'(s_days);
                oor_reg <= 1'b0;
            end
            gdc_pkg::CMD_LEAP: begin
                leap_reg <= gdc_pkg::leap_of(leap_year_sel);
            end
            gdc_pkg::CMD_NEXT_MONTH: begin
                wd_reg <= wd_reg - gdc_pkg::ACC_W'(work_len);
                wm_reg <= wm_reg + gdc_pkg::MONTH_W'(1);
            end
            gdc_pkg::CMD_NEXT_YEAR: begin
                wd_reg <= wd_reg - gdc_pkg::ACC_W'(work_len);
                wm_reg <= gdc_pkg::MONTH_W'(1);
                wy_reg <= wy_reg + gdc_pkg::YEAR_W'(1);
            end
            gdc_pkg::CMD_SATURATE: begin
                // hold at the last representable date
                wd_reg  <= gdc_pkg::ACC_W'(gdc_pkg::LAST_DAY);
                oor_reg <= 1'b1;
            end
            gdc_pkg::CMD_COMMIT: begin
                out_year_reg    <= year_next;
                out_month_reg   <= month_next;
                out_day_reg     <= day_next;
                out_invalid_reg <= out_invalid_next;
                out_earlier_reg <= out_earlier_next;
                out_oor_reg     <= out_oor_next;
            end
            default: begin
                leap_reg <= leap_reg;
            end
        endcase
    end

    assign m_tdata = {6'd0, out_oor_reg, out_earlier_reg, out_invalid_reg,
                      out_day_reg, out_month_reg, out_year_reg};

endmodule

// ===== design/gregorian_date_counter.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_counter
// Gregorian calendar date register with load, advance-by-days and compare.
// ----------------------------------------------------------------------------
// Usage:
//   One word on the s_ channel carries an operation in s_tuser (load, advance,
//   compare) and a date plus a day count in s_tdata. Every accepted word gives
//   exactly one result word on the m_ channel with the stored date after the
//   operation and the invalid, is_earlier and out_of_range flags.
//   Words are handled one at a time; s_tready is high only while the block is
//   waiting for work.
//   Load and compare pass from capture through the leap-year state to commit.
//   Advance also runs the month-step loop, which subtracts one month length
//   per cycle; each year end crossed sends it back through the leap-year
//   unit to refresh the leap flag.
//   Reset sets the date to 1900-01-01 and empties the result register.
//   A result waits in the output register while m_tready is low; the next
//   word is still taken and worked on, and its result is held back until the
//   previous one has gone.
// ----------------------------------------------------------------------------
module gregorian_date_counter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // given_year[13:0], given_month[17:14], given_day[22:18],
    // days_to_add[38:23], zero pad [39]
    input  logic [gdc_pkg::S_DATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [gdc_pkg::OP_W-1:0]     s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cur_year[13:0], cur_month[17:14], cur_day[22:18], invalid[23],
    // is_earlier[24], out_of_range[25], zero pad [31:26]
    output logic [gdc_pkg::M_DATA_W-1:0] m_tdata
);

    gdc_pkg::cmd_t    cmd;
    gdc_pkg::status_t status;

    gdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gdc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_op    (s_tuser),
        .s_year  (s_tdata[13:0]),
        .s_month (s_tdata[17:14]),
        .s_day   (s_tdata[22:18]),
        .s_days  (s_tdata[38:23]),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule
